@@ design/ulf_pkg.sv @@
package ulf_pkg;

  localparam int NUM_EOL_REGS  = 4;
  localparam int MAX_EOL_CHARS = 4;
  localparam int EOL_LIMIT     = (NUM_EOL_REGS < MAX_EOL_CHARS) ? NUM_EOL_REGS : MAX_EOL_CHARS;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [1:0] {
    CMD_BYTE  = 2'd0,
    CMD_TICK  = 2'd1,
    CMD_START = 2'd2,
    CMD_STOP  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    EV_OK      = 2'd0,
    EV_FULL    = 2'd1,
    EV_TIMEOUT = 2'd2
  } ev_t;

  typedef enum logic [2:0] {
    MODE_IDLE = 3'b001,
    MODE_WAIT = 3'b010,
    MODE_RECV = 3'b100
  } mode_t;

  localparam logic [2:0] REG_EOL0    = 3'd0;
  localparam logic [2:0] REG_EOL1    = 3'd1;
  localparam logic [2:0] REG_EOL2    = 3'd2;
  localparam logic [2:0] REG_EOL3    = 3'd3;
  localparam logic [2:0] REG_EOL_CNT = 3'd4;
  localparam logic [2:0] REG_TIMEOUT = 3'd5;

  localparam logic [7:0] TERM_BYTE = 8'd0;

  typedef struct packed {
    logic [NUM_EOL_REGS-1:0][7:0] eol;
    logic [2:0]                   eol_count;
    logic [15:0]                  timeout_ticks;
  } cfg_t;

  typedef struct packed {
    logic       has_byte;
    logic [7:0] byte_out;
    logic       has_event;
    logic [1:0] event_code;
    logic       ready_res;
    logic       last;
  } res_t;

  typedef struct packed {
    res_t       r0;
    res_t       r1;
    logic [1:0] cnt;
  } proc_t;

endpackage

@@ design/uart_line_framer_top.sv @@
// Channel   Direction  Transaction contents
// in_*      slave      tuser[1:0] command; tdata[7:0] byte_in, [15:8] buffer_free
// out_*     master     tdata byte_out; tuser has_byte, has_event, event_code,
//                      ready_res; tlast last
// cfg_*     APB slave  six registers at byte address 4*i, write/read
//
// An accepted item is held in the input register, is decoded and
// pushed into a four-entry result queue; its first result is presented
// from the queue once written there. One item enters per cycle while
// the queue keeps room for two results, so the output drain rate sets the throughput.
// Reset (rst_n low, synchronous) idles the framer and empties the queue.
module uart_line_framer_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [7:0] byte_in, [15:8] buffer_free
  input  logic [1:0]  in_tuser,   // [1:0] command
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] byte_out
  output logic [4:0]  out_tuser,  // [0] has_byte, [1] has_event, [3:2] event_code, [4] ready_res
  output logic        out_tlast,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  ulf_pkg::cfg_t   cfg_r;
  ulf_pkg::proc_t  proc;
  ulf_pkg::res_t   res;
  logic            iv_r;
  logic [1:0]      cmd_r;
  logic [7:0]      byte_r, free_r;
  logic            space, fire;
  logic [2:0]      ridx;
  logic [ulf_pkg::QCNT_W-1:0] qcount;

  assign cfg_pready = 1'b1;
  assign ridx       = cfg_paddr[4:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.eol           <= {8'd0, 8'd0, 8'd10, 8'd13};
      cfg_r.eol_count     <= 3'd2;
      cfg_r.timeout_ticks <= 16'd100;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
      case (ridx)
        ulf_pkg::REG_EOL0:    cfg_r.eol[0]         <= cfg_pwdata[7:0];
        ulf_pkg::REG_EOL1:    cfg_r.eol[1]         <= cfg_pwdata[7:0];
        ulf_pkg::REG_EOL2:    cfg_r.eol[2]         <= cfg_pwdata[7:0];
        ulf_pkg::REG_EOL3:    cfg_r.eol[3]         <= cfg_pwdata[7:0];
        ulf_pkg::REG_EOL_CNT: cfg_r.eol_count      <= cfg_pwdata[2:0];
        ulf_pkg::REG_TIMEOUT: cfg_r.timeout_ticks  <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (ridx)
      ulf_pkg::REG_EOL0:    cfg_prdata = {24'd0, cfg_r.eol[0]};
      ulf_pkg::REG_EOL1:    cfg_prdata = {24'd0, cfg_r.eol[1]};
      ulf_pkg::REG_EOL2:    cfg_prdata = {24'd0, cfg_r.eol[2]};
      ulf_pkg::REG_EOL3:    cfg_prdata = {24'd0, cfg_r.eol[3]};
      ulf_pkg::REG_EOL_CNT: cfg_prdata = {29'd0, cfg_r.eol_count};
      ulf_pkg::REG_TIMEOUT: cfg_prdata = {16'd0, cfg_r.timeout_ticks};
      default:              cfg_prdata = '0;
    endcase
  end

  assign fire      = iv_r && space;
  assign in_tready = !iv_r || fire;

  always_ff @(posedge clk) begin
    if (!rst_n) iv_r <= 1'b0;
    else if (in_tready) iv_r <= in_tvalid;
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      cmd_r  <= in_tuser;
      byte_r <= in_tdata[7:0];
      free_r <= in_tdata[15:8];
    end
  end

  ulf_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .fire       (fire),
    .command    (cmd_r),
    .byte_in    (byte_r),
    .buffer_free(free_r),
    .cfg        (cfg_r),
    .proc       (proc)
  );

  ulf_outq u_outq (
    .clk      (clk),
    .rst_n    (rst_n),
    .proc     (proc),
    .space    (space),
    .out_valid(out_tvalid),
    .out_ready(out_tready),
    .out_res  (res),
    .count    (qcount)
  );

  assign out_tdata = res.byte_out;
  assign out_tuser = {res.ready_res, res.event_code, res.has_event, res.has_byte};
  assign out_tlast = res.last;

  a_qbound: assert property (@(posedge clk) disable iff (!rst_n)
    qcount <= ulf_pkg::QCNT_W'(ulf_pkg::QDEPTH))
    else $error("result queue overflow");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    iv_r && !fire |=> iv_r && $stable(cmd_r) && $stable(byte_r))
    else $error("input register lost a stalled item");

  a_term: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && res.has_event |-> res.byte_out == ulf_pkg::TERM_BYTE && res.ready_res)
    else $error("line event without terminator");

  a_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !res.has_event |-> res.event_code == ulf_pkg::EV_OK)
    else $error("stray event code");

endmodule

@@ design/ulf_core.sv @@
module ulf_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fire,
  input  logic [1:0]        command,
  input  logic [7:0]        byte_in,
  input  logic [7:0]        buffer_free,
  input  ulf_pkg::cfg_t     cfg,
  output ulf_pkg::proc_t    proc
);

  ulf_pkg::mode_t mode_r, mode_nxt;
  logic [15:0]    tleft_r, tleft_nxt;
  logic           ready_r, ready_nxt;
  logic           is_eol;
  logic [2:0]     eol_n;

  // saturate active eol register count
  always_comb begin
    if (cfg.eol_count > 3'(ulf_pkg::EOL_LIMIT)) eol_n = 3'(ulf_pkg::EOL_LIMIT);
    else eol_n = cfg.eol_count;
  end

  always_comb begin
    is_eol = 1'b0;
    for (int i = 0; i < ulf_pkg::EOL_LIMIT; i++) begin
      if ((3'(i) < eol_n) && (cfg.eol[i] == byte_in)) is_eol = 1'b1;
    end
  end

  always_comb begin
    mode_nxt  = mode_r;
    tleft_nxt = tleft_r;
    ready_nxt = ready_r;
    proc      = '0;
    proc.r0.has_byte = 1'b1;
    proc.r1.has_byte = 1'b1;
    proc.r0.ready_res = ready_r;
    proc.r0.last = 1'b1;
    case (ulf_pkg::cmd_t'(command))
      ulf_pkg::CMD_BYTE: begin
        case (mode_r)
          ulf_pkg::MODE_WAIT: begin
            if (!is_eol) begin
              tleft_nxt        = cfg.timeout_ticks;
              mode_nxt         = ulf_pkg::MODE_RECV;
              proc.cnt         = 2'd1;
              proc.r0.byte_out = byte_in;
            end
          end
          ulf_pkg::MODE_RECV: begin
            if (buffer_free == 8'd1) begin
              ready_nxt          = 1'b1;
              tleft_nxt          = '0;
              mode_nxt           = ulf_pkg::MODE_IDLE;
              proc.cnt           = 2'd1;
              proc.r0.byte_out   = ulf_pkg::TERM_BYTE;
              proc.r0.has_event  = 1'b1;
              proc.r0.event_code = ulf_pkg::EV_FULL;
              proc.r0.ready_res  = 1'b1;
            end else if (is_eol) begin
              ready_nxt          = 1'b1;
              tleft_nxt          = '0;
              mode_nxt           = ulf_pkg::MODE_IDLE;
              proc.cnt           = 2'd2;
              proc.r0.byte_out   = byte_in;
              proc.r0.last       = 1'b0;
              proc.r1.byte_out   = ulf_pkg::TERM_BYTE;
              proc.r1.has_event  = 1'b1;
              proc.r1.event_code = ulf_pkg::EV_OK;
              proc.r1.ready_res  = 1'b1;
              proc.r1.last       = 1'b1;
            end else begin
              tleft_nxt        = cfg.timeout_ticks;
              proc.cnt         = 2'd1;
              proc.r0.byte_out = byte_in;
            end
          end
          default: ;
        endcase
      end
      ulf_pkg::CMD_TICK: begin
        if (tleft_r != '0) begin
          tleft_nxt = tleft_r - 16'd1;
          if ((tleft_r == 16'd1) && (mode_r != ulf_pkg::MODE_IDLE)) begin
            ready_nxt          = 1'b1;
            mode_nxt           = ulf_pkg::MODE_IDLE;
            proc.cnt           = 2'd1;
            proc.r0.byte_out   = ulf_pkg::TERM_BYTE;
            proc.r0.has_event  = 1'b1;
            proc.r0.event_code = ulf_pkg::EV_TIMEOUT;
            proc.r0.ready_res  = 1'b1;
          end
        end
      end
      ulf_pkg::CMD_START: begin
        ready_nxt = 1'b0;
        tleft_nxt = '0;
        mode_nxt  = ulf_pkg::MODE_WAIT;
      end
      default: begin
        ready_nxt = 1'b1;
        tleft_nxt = '0;
        mode_nxt  = ulf_pkg::MODE_IDLE;
      end
    endcase
    if (!fire) proc.cnt = 2'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= ulf_pkg::MODE_IDLE;
      tleft_r <= '0;
      ready_r <= 1'b0;
    end else if (fire) begin
      mode_r  <= mode_nxt;
      tleft_r <= tleft_nxt;
      ready_r <= ready_nxt;
    end
  end

endmodule

@@ design/ulf_outq.sv @@
module ulf_outq (
  input  logic                        clk,
  input  logic                        rst_n,
  input  ulf_pkg::proc_t              proc,
  output logic                        space,
  output logic                        out_valid,
  input  logic                        out_ready,
  output ulf_pkg::res_t               out_res,
  output logic [ulf_pkg::QCNT_W-1:0]  count
);

  ulf_pkg::res_t                 mem [ulf_pkg::QDEPTH];
  logic [ulf_pkg::QPTR_W-1:0]    wr_r, rd_r;
  logic [ulf_pkg::QCNT_W-1:0]    cnt_r, cnt_nxt;
  logic                          pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = (cnt_r != '0);
  assign out_res   = mem[rd_r];
  assign count     = cnt_r;
  // room for the worst case of two results per item
  assign space     = (cnt_r <= ulf_pkg::QCNT_W'(ulf_pkg::QDEPTH - 2));

  assign cnt_nxt = cnt_r + ulf_pkg::QCNT_W'(proc.cnt) - ulf_pkg::QCNT_W'(pop);

  always_ff @(posedge clk) begin
    if (proc.cnt != 2'd0) mem[wr_r] <= proc.r0;
    if (proc.cnt == 2'd2) mem[wr_r + ulf_pkg::QPTR_W'(1)] <= proc.r1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_r + ulf_pkg::QPTR_W'(proc.cnt);
      rd_r  <= rd_r + ulf_pkg::QPTR_W'(pop);
      cnt_r <= cnt_nxt;
    end
  end

endmodule

@@ verif/tb_top.sv @@
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ulf_pkg::*;

  localparam int          SETTLE_CYC  = 8;
  localparam int          STALL_LIMIT = 3000;
  localparam int          NUM_PHASES  = 6;
  localparam int          PHASE_ITEMS = 255;
  localparam logic [2:0]  REG_UNUSED  = 3'd6;

  typedef enum logic { ROW_ITEM, ROW_REG } row_kind_t;

  typedef struct {
    row_kind_t   kind;
    cmd_t        cmd;
    logic [7:0]  byte_in;
    logic [7:0]  free;
    logic [2:0]  idx;
    int          width;
    logic [31:0] val;
    bit          typed;
    int          n;
    res_t        r0;
    res_t        r1;
  } vec_t;

  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic        in_tvalid   = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata    = '0;   // [7:0] byte_in, [15:8] buffer_free
  logic [1:0]  in_tuser    = '0;   // [1:0] command
  logic        out_tvalid;
  logic        out_tready  = 1'b0;
  logic [7:0]  out_tdata;          // [7:0] byte_out
  logic [4:0]  out_tuser;          // [0] has_byte, [1] has_event, [3:2] event_code, [4] ready_res
  logic        out_tlast;
  logic        cfg_psel    = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite  = 1'b0;
  logic [4:0]  cfg_paddr   = '0;
  logic [31:0] cfg_pwdata  = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  uart_line_framer_top u_dut (.*);

  always #1 clk = ~clk;

  // framer state and register copies, at their reset values
  logic [7:0]  eol_tab [NUM_EOL_REGS] = '{8'd13, 8'd10, 8'd0, 8'd0};
  logic [2:0]  eol_used   = 3'd2;
  logic [15:0] tmo_reload = 16'd100;
  mode_t       fr_mode    = MODE_IDLE;
  logic [15:0] fr_tleft   = '0;
  logic        fr_ready   = 1'b0;

  res_t pending_pushes[$];
  vec_t rows[$];
  int   err_cnt    = 0;
  int   live_items = 0;
  int   send_idle  = 0;
  int   recv_idle  = 0;
  int   stall_cnt  = 0;

  function automatic res_t mk_res(logic [7:0] b, logic ev, ev_t code, logic rdy, logic lst);
    res_t r;
    r = '{1'b1, b, ev, (ev ? code : EV_OK), rdy, lst};
    return r;
  endfunction

  function automatic bit is_eol(logic [7:0] b);
    int n;
    n = eol_used;
    if (n > EOL_LIMIT) n = EOL_LIMIT;
    for (int i = 0; i < n; i++)
      if (eol_tab[i] == b) return 1'b1;
    return 1'b0;
  endfunction

  function automatic void stop_line();
    fr_ready = 1'b1;
    fr_tleft = '0;
    fr_mode  = MODE_IDLE;
  endfunction

  // advances the framer by one transaction, returns how many pushes it makes
  function automatic int predict_pushes(cmd_t c, logic [7:0] b, logic [7:0] f,
                                        output res_t r0, output res_t r1);
    int n;
    n  = 0;
    r0 = '0;
    r1 = '0;
    case (c)
      CMD_BYTE: begin
        if (fr_mode == MODE_WAIT) begin
          if (!is_eol(b)) begin
            fr_tleft = tmo_reload;
            fr_mode  = MODE_RECV;
            r0 = mk_res(b, 1'b0, EV_OK, fr_ready, 1'b1);
            n  = 1;
          end
        end else if (fr_mode == MODE_RECV) begin
          // full check wins over the end-of-line test
          if (f == 8'd1) begin
            stop_line();
            r0 = mk_res(TERM_BYTE, 1'b1, EV_FULL, fr_ready, 1'b1);
            n  = 1;
          end else if (is_eol(b)) begin
            r0 = mk_res(b, 1'b0, EV_OK, fr_ready, 1'b0);
            stop_line();
            r1 = mk_res(TERM_BYTE, 1'b1, EV_OK, fr_ready, 1'b1);
            n  = 2;
          end else begin
            fr_tleft = tmo_reload;
            r0 = mk_res(b, 1'b0, EV_OK, fr_ready, 1'b1);
            n  = 1;
          end
        end
      end
      CMD_TICK: begin
        if (fr_tleft != '0) begin
          fr_tleft = fr_tleft - 16'd1;
          if (fr_tleft == '0 && fr_mode != MODE_IDLE) begin
            fr_ready = 1'b1;
            fr_mode  = MODE_IDLE;
            r0 = mk_res(TERM_BYTE, 1'b1, EV_TIMEOUT, fr_ready, 1'b1);
            n  = 1;
          end
        end
      end
      CMD_START: begin
        fr_ready = 1'b0;
        fr_tleft = '0;
        fr_mode  = MODE_WAIT;
      end
      default: stop_line();
    endcase
    return n;
  endfunction

  function automatic void add_item(cmd_t c, logic [7:0] b, logic [7:0] f);
    vec_t v;
    v = '{kind: ROW_ITEM, cmd: c, byte_in: b, free: f, idx: '0, width: 0, val: '0,
          typed: 1'b0, n: 0, r0: '0, r1: '0};
    rows.push_back(v);
  endfunction

  function automatic void add_typed(cmd_t c, logic [7:0] b, logic [7:0] f, int n,
                                    res_t r0, res_t r1);
    vec_t v;
    v = '{kind: ROW_ITEM, cmd: c, byte_in: b, free: f, idx: '0, width: 0, val: '0,
          typed: 1'b1, n: n, r0: r0, r1: r1};
    rows.push_back(v);
  endfunction

  function automatic void add_reg(logic [2:0] idx, int width, logic [31:0] val);
    vec_t v;
    v = '{kind: ROW_REG, cmd: CMD_BYTE, byte_in: '0, free: '0, idx: idx, width: width,
          val: val, typed: 1'b0, n: 0, r0: '0, r1: '0};
    rows.push_back(v);
  endfunction

  task automatic send_item(cmd_t c, logic [7:0] b, logic [7:0] f, bit typed, int n,
                           res_t r0, res_t r1);
    int   gap;
    int   got;
    res_t p0;
    res_t p1;
    gap = 0;
    while ($urandom_range(0, 99) < send_idle) gap++;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {f, b};
    in_tuser  <= c;
    do @(posedge clk); while (!in_tready);
    live_items++;
    got = predict_pushes(c, b, f, p0, p1);
    if (typed) begin
      got = n;
      p0  = r0;
      p1  = r1;
    end
    if (got > 0) pending_pushes.push_back(p0);
    if (got > 1) pending_pushes.push_back(p1);
  endtask

  // back-to-back APB writes keep psel high; the caller drops it after the batch
  task automatic write_reg(logic [2:0] idx, int width, logic [31:0] val);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= ({$urandom()} << width) | val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (idx <= REG_EOL3)
      eol_tab[idx] = val[7:0];
    else if (idx == REG_EOL_CNT)
      eol_used = val[2:0];
    else if (idx == REG_TIMEOUT)
      tmo_reload = val[15:0];
  endtask

  // stop sending, wait for every push, then let items with no result retire
  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_pushes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic cmp(string name, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      err_cnt++;
    end
  endtask

  always @(posedge clk) begin : out_chk
    res_t want;
    if (rst_n) out_tready <= ($urandom_range(0, 99) >= recv_idle);
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_pushes.size() == 0) begin
        $error("unexpected result transaction: byte_out %0h", out_tdata);
        err_cnt++;
      end else begin
        want = pending_pushes.pop_front();
        cmp("has_byte",   8'(want.has_byte),   8'(out_tuser[0]));
        cmp("byte_out",   want.byte_out,       out_tdata);
        cmp("has_event",  8'(want.has_event),  8'(out_tuser[1]));
        cmp("event_code", 8'(want.event_code), 8'(out_tuser[3:2]));
        cmp("ready_res",  8'(want.ready_res),  8'(out_tuser[4]));
        cmp("last",       8'(want.last),       8'(out_tlast));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_psel && cfg_penable))
      stall_cnt <= 0;
    else
      stall_cnt <= stall_cnt + 1;
    if (stall_cnt >= STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    int   r;
    cmd_t c;
    logic [7:0] b;
    logic [7:0] f;

    // default registers: eol 0x0d/0x0a, two in use, timeout 100
    add_typed(CMD_BYTE,  8'h41, 8'h10, 0, '0, '0);   // idle byte dropped
    add_typed(CMD_TICK,  8'h00, 8'h00, 0, '0, '0);
    add_typed(CMD_STOP,  8'h00, 8'h00, 0, '0, '0);
    add_typed(CMD_START, 8'h00, 8'h00, 0, '0, '0);
    add_typed(CMD_BYTE,  8'h0d, 8'h00, 0, '0, '0);   // eol discarded while waiting
    add_typed(CMD_BYTE,  8'h0a, 8'h01, 0, '0, '0);   // no full check while waiting
    add_typed(CMD_BYTE,  8'hff, 8'hff, 1, mk_res(8'hff, 1'b0, EV_OK, 1'b0, 1'b1), '0);
    add_typed(CMD_BYTE,  8'h00, 8'h00, 1, mk_res(8'h00, 1'b0, EV_OK, 1'b0, 1'b1), '0);
    add_typed(CMD_BYTE,  8'h0d, 8'h02, 2, mk_res(8'h0d, 1'b0, EV_OK, 1'b0, 1'b0),
              mk_res(TERM_BYTE, 1'b1, EV_OK, 1'b1, 1'b1));
    add_typed(CMD_START, 8'h00, 8'h00, 0, '0, '0);
    add_typed(CMD_BYTE,  8'h55, 8'h01, 1, mk_res(8'h55, 1'b0, EV_OK, 1'b0, 1'b1), '0);
    add_typed(CMD_BYTE,  8'h0a, 8'h01, 1, mk_res(TERM_BYTE, 1'b1, EV_FULL, 1'b1, 1'b1), '0);
    add_typed(CMD_BYTE,  8'h66, 8'h03, 0, '0, '0);
    add_reg(REG_TIMEOUT, 16, 32'd2);
    add_reg(REG_UNUSED, 32, 32'hffff_ffff);
    add_typed(CMD_START, 8'h00, 8'h00, 0, '0, '0);
    add_typed(CMD_BYTE,  8'h31, 8'h80, 1, mk_res(8'h31, 1'b0, EV_OK, 1'b0, 1'b1), '0);
    add_typed(CMD_TICK,  8'h00, 8'h00, 0, '0, '0);
    add_typed(CMD_TICK,  8'h00, 8'h00, 1, mk_res(TERM_BYTE, 1'b1, EV_TIMEOUT, 1'b1, 1'b1), '0);
    add_typed(CMD_TICK,  8'h00, 8'h00, 0, '0, '0);
    add_reg(REG_EOL3, 8, 32'h7e);
    add_reg(REG_EOL_CNT, 3, 32'd7);                  // saturates to four in use
    add_typed(CMD_START, 8'h00, 8'h00, 0, '0, '0);
    add_typed(CMD_BYTE,  8'h7e, 8'h00, 0, '0, '0);
    add_typed(CMD_BYTE,  8'h00, 8'h00, 0, '0, '0);
    add_item(CMD_BYTE,  8'h20, 8'h7f);
    add_item(CMD_TICK,  8'h00, 8'h00);
    add_item(CMD_BYTE,  8'h7e, 8'hfe);
    add_item(CMD_START, 8'h00, 8'h00);
    add_item(CMD_BYTE,  8'h5a, 8'h40);
    add_item(CMD_STOP,  8'h00, 8'h00);
    add_item(CMD_BYTE,  8'h44, 8'h00);

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    send_idle = 26;
    recv_idle = 63;

    foreach (rows[i]) begin
      if (rows[i].kind == ROW_REG) begin
        if (in_tvalid) settle();
        write_reg(rows[i].idx, rows[i].width, rows[i].val);
      end else begin
        if (cfg_psel) begin
          cfg_psel    <= 1'b0;
          cfg_penable <= 1'b0;
        end
        send_item(rows[i].cmd, rows[i].byte_in, rows[i].free, rows[i].typed, rows[i].n,
                  rows[i].r0, rows[i].r1);
      end
    end

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      settle();
      case (ph / 2)
        0:       begin send_idle = 26; recv_idle = 63; end
        1:       begin send_idle = 63; recv_idle = 26; end
        default: begin send_idle = 0;  recv_idle = 0;  end
      endcase
      if (ph == 1) begin
        write_reg(REG_EOL0, 8, 32'h00);
        write_reg(REG_EOL1, 8, 32'hff);
      end else begin
        write_reg(REG_EOL0, 8, $urandom_range(0, 255));
        write_reg(REG_EOL1, 8, $urandom_range(0, 255));
      end
      write_reg(REG_EOL2, 8, $urandom_range(0, 255));
      write_reg(REG_EOL3, 8, $urandom_range(0, 255));
      case (ph)
        0: begin
          write_reg(REG_EOL_CNT, 3, 32'd0);
          write_reg(REG_TIMEOUT, 16, 32'd0);           // timeout disabled
        end
        1: begin
          write_reg(REG_EOL_CNT, 3, 32'd4);
          write_reg(REG_TIMEOUT, 16, 32'hffff);
        end
        2: begin
          write_reg(REG_EOL_CNT, 3, $urandom_range(0, 7));
          write_reg(REG_TIMEOUT, 16, 32'd1);
        end
        default: begin
          write_reg(REG_EOL_CNT, 3, $urandom_range(0, 7));
          write_reg(REG_TIMEOUT, 16, $urandom_range(1, 12));
        end
      endcase
      cfg_psel    <= 1'b0;
      cfg_penable <= 1'b0;

      live_items = 0;
      while (live_items < PHASE_ITEMS) begin
        r = $urandom_range(0, 99);
        if (fr_mode == MODE_IDLE)
          c = (r < 75) ? CMD_START : cmd_t'($urandom_range(0, 3));
        else if (r < 65)
          c = CMD_BYTE;
        else if (r < 88)
          c = CMD_TICK;
        else if (r < 94)
          c = CMD_START;
        else
          c = CMD_STOP;
        b = ($urandom_range(0, 99) < 30) ? eol_tab[$urandom_range(0, NUM_EOL_REGS - 1)]
                                          : 8'($urandom_range(0, 255));
        f = ($urandom_range(0, 99) < 6) ? 8'd1 : 8'($urandom_range(0, 255));
        send_item(c, b, f, 1'b0, 0, '0, '0);
      end
    end
    settle();

    if (err_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
